### design/ucm_pkg.sv
package ucm_pkg;

  // Longest line held is LINE_CAPACITY-1 bytes.
  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] RSP_PONG       = 3'd0;
  localparam logic [2:0] RSP_VERSION    = 3'd1;
  localparam logic [2:0] RSP_STATUS     = 3'd2;
  localparam logic [2:0] RSP_RESETTING  = 3'd3;
  localparam logic [2:0] RSP_UNKNOWN    = 3'd4;
  localparam logic [2:0] RSP_TOO_LONG   = 3'd5;
  localparam logic [2:0] RSP_READ_ERROR = 3'd6;

  // Command words, left aligned in 16 characters and padded with zero bytes.
  localparam int NUM_WORDS = 4;
  localparam int WORD_CHARS = 16;
  localparam int WORD_PING = 0;
  localparam int WORD_VERSION = 1;
  localparam int WORD_STATUS = 2;
  localparam int WORD_RESET = 3;

  localparam logic [8*WORD_CHARS-1:0] WORD_TXT [NUM_WORDS] = '{
    {"PING", 96'h0},
    {"GET_", "VERSION", 40'h0},
    {"GET_", "STATUS", 48'h0},
    {"RESET", 88'h0}
  };
  localparam logic [LEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
    LEN_W'(4), LEN_W'(11), LEN_W'(10), LEN_W'(5)
  };

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       read_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0] response;
    logic       reset_request;
  } result_t;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_END,
    CMD_RDERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] rx_byte;
  } cmd_t;

endpackage

### design/ucm_front.sv
module ucm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ucm_pkg::in_item_t item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ucm_pkg::cmd_t     cmd
);
  import ucm_pkg::*;

  // Classified commands wait in a two-entry queue for the back end.
  cmd_t       slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;

  cmd_t       cmd_in;
  logic       keep;
  logic       write;
  logic       read;

  always_comb begin
    cmd_in.rx_byte = item.rx_byte;
    if (item.read_error) begin
      cmd_in.kind = CMD_RDERR;
    end else if (item.rx_byte == CH_LF) begin
      cmd_in.kind = CMD_END;
    end else begin
      cmd_in.kind = CMD_APPEND;
    end
  end

  // Carriage returns never reach the queue.
  assign keep  = item.read_error || (item.rx_byte != CH_CR);
  assign full  = (count == 2'd2);
  assign write = push && !full && keep;
  assign read  = cmd_valid && cmd_ready;

  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count  <= count + {1'b0, write} - {1'b0, read};
      wr_ptr <= wr_ptr ^ write;
      rd_ptr <= rd_ptr ^ read;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

endmodule

### design/ucm_back.sv
module ucm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  ucm_pkg::cmd_t    cmd,
  output logic             empty,
  input  logic             pop,
  output ucm_pkg::result_t result
);
  import ucm_pkg::*;

  // Line state: the match against each word is tracked as the bytes arrive.
  logic [LEN_W-1:0]     line_length;
  logic [LEN_W-1:0]     line_length_next;
  logic [LEN_W-1:0]     text_len;
  logic [LEN_W-1:0]     text_len_next;
  logic                 zero_seen;
  logic                 zero_seen_next;
  logic [NUM_WORDS-1:0] match;
  logic [NUM_WORDS-1:0] match_next;
  logic [NUM_WORDS-1:0] hit;
  logic [3:0]           pos;

  // Two-entry result queue.
  result_t    slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       take;
  logic       res_valid;
  result_t    res;
  logic       read;

  assign cmd_ready = (count != 2'd2);
  assign take      = cmd_valid && cmd_ready;
  assign pos       = text_len[3:0];

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      hit[i] = (32'(text_len) < WORD_CHARS) &&
               (cmd.rx_byte == WORD_TXT[i][8*(WORD_CHARS-1-32'(pos)) +: 8]);
    end
  end

  always_comb begin
    line_length_next = line_length;
    text_len_next    = text_len;
    zero_seen_next   = zero_seen;
    match_next       = match;
    res_valid        = 1'b0;
    res              = '0;
    if (take) begin
      unique case (cmd.kind)
        CMD_RDERR: begin
          res_valid    = 1'b1;
          res.response = RSP_READ_ERROR;
        end
        CMD_END: begin
          line_length_next = '0;
          text_len_next    = '0;
          zero_seen_next   = 1'b0;
          match_next       = '1;
          res_valid        = 1'b1;
          priority if (match[WORD_PING] && text_len == WORD_LEN[WORD_PING]) begin
            res.response = RSP_PONG;
          end else if (match[WORD_VERSION] && text_len == WORD_LEN[WORD_VERSION]) begin
            res.response = RSP_VERSION;
          end else if (match[WORD_STATUS] && text_len == WORD_LEN[WORD_STATUS]) begin
            res.response = RSP_STATUS;
          end else if (match[WORD_RESET] && text_len == WORD_LEN[WORD_RESET]) begin
            res.response      = RSP_RESETTING;
            res.reset_request = 1'b1;
          end else if (text_len != '0) begin
            res.response = RSP_UNKNOWN;
          end else begin
            res_valid = 1'b0;
          end
        end
        CMD_APPEND: begin
          if (line_length >= LEN_W'(LINE_CAPACITY - 1)) begin
            line_length_next = '0;
            text_len_next    = '0;
            zero_seen_next   = 1'b0;
            match_next       = '1;
            res_valid        = 1'b1;
            res.response     = RSP_TOO_LONG;
          end else begin
            line_length_next = line_length + LEN_W'(1);
            // A zero byte ends the text that is matched.
            if (!zero_seen) begin
              if (cmd.rx_byte == 8'h00) begin
                zero_seen_next = 1'b1;
              end else begin
                match_next    = match & hit;
                text_len_next = text_len + LEN_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      text_len    <= '0;
      zero_seen   <= 1'b0;
      match       <= '1;
    end else begin
      line_length <= line_length_next;
      text_len    <= text_len_next;
      zero_seen   <= zero_seen_next;
      match       <= match_next;
    end
  end

  assign empty  = (count == 2'd0);
  assign result = slot[rd_ptr];
  assign read   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count  <= count + {1'b0, res_valid} - {1'b0, read};
      wr_ptr <= wr_ptr ^ res_valid;
      rd_ptr <= rd_ptr ^ read;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      slot[wr_ptr] <= res;
    end
  end

endmodule

### design/uart_command_line_matcher_top.sv
// A result reaches the result ports from the input byte that causes it through
// the front queue register, then the result queue.
// Throughput: one byte per cycle while neither queue is full; the back end
// updates the line state per byte, and the two-entry queues let either side stall alone.
// Reset (rst, synchronous, active high) empties both queues and clears the line.
module uart_command_line_matcher_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ucm_pkg::in_item_t item,
  output logic              empty,
  input  logic              pop,
  output ucm_pkg::result_t  result
);
  import ucm_pkg::*;

  // Commands handed from the classifier to the line engine.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // The front end turns each byte into an append, end-of-line or read-error
  // command and drops carriage returns. It holds up to two commands, so a
  // transfer is still taken while the back end is stalled, until the queue is full.
  ucm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The back end keeps the line length and a running per-word match, so a
  // line feed is classified without storing the text of the line.
  // Results wait in a two-entry queue until they are popped.
  ucm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
